// ===== hdl/gmh_pkg.sv =====
// ----------------------------------------------------------------------------
// Markup to HTML stream: shared definitions
// Types, codes and character tables used by the front, the queue and the back.
// ----------------------------------------------------------------------------
package gmh_pkg;

  localparam logic [7:0] KEY_RESET = 8'h1A;
  localparam logic [7:0] CARET     = 8'h5E;
  localparam logic [7:0] RUN_MARK  = 8'hFF;
  localparam logic [7:0] SPACE     = 8'h20;
  localparam logic [7:0] DOT       = 8'h2E;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CARET = 3'd1,
    PH_ATTR1 = 3'd2,
    PH_ATTR2 = 3'd3,
    PH_HEXHI = 3'd4,
    PH_HEXLO = 3'd5,
    PH_COUNT = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    SEG_NONE,
    SEG_CHAR,
    SEG_MARK,
    SEG_LT,
    SEG_GT,
    SEG_AMP,
    SEG_OB,
    SEG_CB,
    SEG_OU,
    SEG_CU
  } seg_t;

  typedef struct packed {
    seg_t       s0;
    seg_t       s1;
    logic [7:0] ch;
    logic [7:0] rep;
    logic       eol;
  } cmd_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [7:0] u;
    u = b;
    if (b >= "a" && b <= "z") u = b - 8'd32;
    if (u >= "0" && u <= "9") return 4'(u - "0");
    if (u >= "A" && u <= "F") return 4'(u - "A" + 8'd10);
    return 4'd0;
  endfunction

  function automatic logic [7:0] clean_byte(input logic [7:0] b);
    logic [7:0] r;
    case (b) inside
      8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB9, 8'hBA, 8'hC3, 8'hCC: r = "|";
      8'hC4, 8'hC1, 8'hC2, 8'hC6, 8'hC7, 8'hCA,
      8'hCB, 8'hCD, 8'hCF, 8'hD0, 8'hD1, 8'hD2: r = "-";
      8'hB7, 8'hB8, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF, 8'hC0, 8'hC5, 8'hC8,
      8'hC9, 8'hCE, [8'hD3:8'hDA]: r = "+";
      [8'hDB:8'hDF], 8'hB0, 8'hB1, 8'hB2: r = "#";
      default: begin
        if ((b < PRINT_LO || b > PRINT_HI) && b != 8'h00) r = DOT;
        else r = b;
      end
    endcase
    return r;
  endfunction

  function automatic logic [2:0] seg_len(input seg_t s);
    logic [2:0] n;
    unique case (s)
      SEG_LT, SEG_GT, SEG_CB, SEG_CU: n = 3'd4;
      SEG_AMP:                        n = 3'd5;
      SEG_OB, SEG_OU:                 n = 3'd3;
      default:                        n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] seg_char(input seg_t s, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    unique case (s)
      SEG_LT:  c = (i == 3'd0) ? "&" : (i == 3'd1) ? "l" : (i == 3'd2) ? "t" : ";";
      SEG_GT:  c = (i == 3'd0) ? "&" : (i == 3'd1) ? "g" : (i == 3'd2) ? "t" : ";";
      SEG_AMP: c = (i == 3'd0) ? "&" : (i == 3'd1) ? "a" : (i == 3'd2) ? "m" :
                   (i == 3'd3) ? "p" : ";";
      SEG_OB:  c = (i == 3'd0) ? "<" : (i == 3'd1) ? "B" : ">";
      SEG_OU:  c = (i == 3'd0) ? "<" : (i == 3'd1) ? "U" : ">";
      SEG_CB:  c = (i == 3'd0) ? "<" : (i == 3'd1) ? "/" : (i == 3'd2) ? "B" : ">";
      SEG_CU:  c = (i == 3'd0) ? "<" : (i == 3'd1) ? "/" : (i == 3'd2) ? "U" : ">";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/gmh_front.sv =====
// ----------------------------------------------------------------------------
// Markup to HTML stream: front end
// Unmasks each accepted item, runs the escape machine and issues at most one command.
// ----------------------------------------------------------------------------
module gmh_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [7:0]    cfg_data,
  input  logic          accept,
  input  logic [7:0]    raw_byte,
  output logic          cmd_valid,
  output gmh_pkg::cmd_t cmd
);
  import gmh_pkg::*;

  logic [7:0] xor_key;
  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic       bold_open;
  logic       bold_open_next;
  logic       underline_open;
  logic       underline_open_next;
  logic [7:0] b;

  assign b = raw_byte ^ xor_key;

  function automatic cmd_t html_cmd(input logic [7:0] c);
    cmd_t r;
    r = '{s0: SEG_CHAR, s1: SEG_NONE, ch: c, rep: 8'd1, eol: 1'b0};
    if (c == "<") r.s0 = SEG_LT;
    else if (c == ">") r.s0 = SEG_GT;
    else if (c == "&") r.s0 = SEG_AMP;
    else if (c == 8'h00) r.ch = SPACE;
    return r;
  endfunction

  function automatic cmd_t idle_cmd(input logic [7:0] c);
    cmd_t r;
    r = '{s0: SEG_NONE, s1: SEG_NONE, ch: 8'h00, rep: 8'd0, eol: 1'b0};
    if (c != CARET && c != RUN_MARK) r = html_cmd(clean_byte(c));
    return r;
  endfunction

  function automatic cmd_t close_cmd(input logic bo, input logic uo, input logic eol);
    cmd_t r;
    r = '{s0: SEG_NONE, s1: SEG_NONE, ch: 8'h00, rep: 8'd0, eol: eol};
    if (bo) r.s0 = SEG_CB;
    else if (uo) r.s0 = SEG_CU;
    else if (eol) r.s0 = SEG_MARK;
    if (bo && uo) r.s1 = SEG_CU;
    return r;
  endfunction

  function automatic phase_t idle_phase(input logic [7:0] c);
    phase_t p;
    p = PH_IDLE;
    if (c == CARET) p = PH_CARET;
    else if (c == RUN_MARK) p = PH_COUNT;
    return p;
  endfunction

  always_comb begin
    phase_next = PH_IDLE;
    if (b != 8'h00) begin
      unique case (phase)
        PH_CARET: begin
          case (b) inside
            "a", "A": phase_next = PH_ATTR1;
            "c", "C": phase_next = PH_HEXHI;
            "b", "B", "n", "N", "r", "R", "u", "U", CARET: phase_next = PH_IDLE;
            default: phase_next = idle_phase(b);
          endcase
        end
        PH_ATTR1: phase_next = PH_ATTR2;
        PH_HEXHI: phase_next = PH_HEXLO;
        PH_ATTR2, PH_HEXLO, PH_COUNT: phase_next = PH_IDLE;
        default: phase_next = idle_phase(b);
      endcase
    end
  end

  always_comb begin
    cmd                 = '{s0: SEG_NONE, s1: SEG_NONE, ch: 8'h00, rep: 8'd0, eol: 1'b0};
    high_nibble_next    = high_nibble;
    bold_open_next      = bold_open;
    underline_open_next = underline_open;
    if (b == 8'h00) begin
      cmd                 = close_cmd(bold_open, underline_open, 1'b1);
      bold_open_next      = 1'b0;
      underline_open_next = 1'b0;
    end else begin
      unique case (phase)
        PH_CARET: begin
          case (b) inside
            "a", "A", "c", "C", "r", "R": cmd.s0 = SEG_NONE;
            "b", "B": begin
              cmd.s0         = bold_open ? SEG_CB : SEG_OB;
              bold_open_next = !bold_open;
            end
            "u", "U": begin
              cmd.s0              = underline_open ? SEG_CU : SEG_OU;
              underline_open_next = !underline_open;
            end
            "n", "N": begin
              cmd                 = close_cmd(bold_open, underline_open, 1'b0);
              bold_open_next      = 1'b0;
              underline_open_next = 1'b0;
            end
            CARET: cmd = '{s0: SEG_CHAR, s1: SEG_NONE, ch: CARET, rep: 8'd1, eol: 1'b0};
            default: cmd = idle_cmd(b);
          endcase
        end
        PH_ATTR1, PH_ATTR2: cmd.s0 = SEG_NONE;
        PH_HEXHI: high_nibble_next = hex_digit(b);
        PH_HEXLO: cmd = html_cmd(clean_byte({high_nibble, hex_digit(b)}));
        PH_COUNT: cmd = '{s0: SEG_CHAR, s1: SEG_NONE, ch: SPACE, rep: b, eol: 1'b0};
        default: cmd = idle_cmd(b);
      endcase
    end
  end

  assign cmd_valid = accept && (cmd.s0 != SEG_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key        <= KEY_RESET;
      phase          <= PH_IDLE;
      high_nibble    <= 4'd0;
      bold_open      <= 1'b0;
      underline_open <= 1'b0;
    end else begin
      if (cfg_write) xor_key <= cfg_data;
      if (accept) begin
        phase          <= phase_next;
        high_nibble    <= high_nibble_next;
        bold_open      <= bold_open_next;
        underline_open <= underline_open_next;
      end
    end
  end

endmodule

// ===== hdl/gmh_queue.sv =====
// ----------------------------------------------------------------------------
// Markup to HTML stream: command queue
// Short first-in first-out queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module gmh_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  gmh_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output gmh_pkg::cmd_t rd_data,
  output logic          empty
);
  import gmh_pkg::*;

  cmd_t              store [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) store[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

// ===== hdl/gmh_back.sv =====
// ----------------------------------------------------------------------------
// Markup to HTML stream: back end
// Expands the queue head command into result items, one a cycle while popped.
// ----------------------------------------------------------------------------
module gmh_back (
  input  logic          clk,
  input  logic          rst,
  input  gmh_pkg::cmd_t head,
  input  logic          head_empty,
  output logic          head_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic [7:0]    repeat_count,
  output logic          end_of_line,
  output logic          last
);
  import gmh_pkg::*;

  logic       out_valid;
  logic [2:0] pos;
  logic       seg_sel;
  seg_t       cur;
  logic       seg_end;
  logic       cmd_end;
  logic       advance;
  logic [7:0] byte_next;
  logic [7:0] rep_next;

  assign cur     = seg_sel ? head.s1 : head.s0;
  assign seg_end = (pos == seg_len(cur) - 3'd1);
  assign cmd_end = seg_end && (seg_sel || head.s1 == SEG_NONE);
  assign advance = !head_empty && (!out_valid || pop);
  assign head_pop = advance && cmd_end;
  assign empty   = !out_valid;

  always_comb begin
    if (cur == SEG_CHAR) begin
      byte_next = head.ch;
      rep_next  = head.rep;
    end else if (cur == SEG_MARK) begin
      byte_next = 8'h00;
      rep_next  = 8'd0;
    end else begin
      byte_next = seg_char(cur, pos);
      rep_next  = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte     <= byte_next;
      repeat_count <= rep_next;
      end_of_line  <= cmd_end && head.eol;
      last         <= cmd_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 3'd0;
      seg_sel   <= 1'b0;
    end else begin
      if (advance) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (advance) begin
        if (cmd_end) begin
          pos     <= 3'd0;
          seg_sel <= 1'b0;
        end else if (seg_end) begin
          pos     <= 3'd0;
          seg_sel <= 1'b1;
        end else begin
          pos <= pos + 3'd1;
        end
      end
    end
  end

endmodule

// ===== hdl/guide_markup_to_html_stream.sv =====
// ----------------------------------------------------------------------------
// Markup to HTML stream: top level
// Help-text markup bytes in, HTML characters, space runs and line ends out.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while each gives at most one result and the
// results are popped; an item giving n results holds the back end, which emits
// one result a cycle while popped, until all n are out. A four-entry command
// queue lets the front keep taking items meanwhile.
// Reset: synchronous; key 0x1A, escape machine idle, tags closed, queue and output empty.
module guide_markup_to_html_stream (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] raw_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [7:0] repeat_count,
  output logic       end_of_line,
  output logic       last
);
  import gmh_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t head;
  logic head_empty;
  logic head_pop;

  assign accept = push && !full;

  gmh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .raw_byte  (raw_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  gmh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head),
    .empty   (head_empty)
  );

  gmh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_empty   (head_empty),
    .head_pop     (head_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .repeat_count (repeat_count),
    .end_of_line  (end_of_line),
    .last         (last)
  );

endmodule

// ===== hdl/gmh_checker.sv =====
// ----------------------------------------------------------------------------
// Markup to HTML stream: port checker
// Properties on what the top level's ports show over time.
// ----------------------------------------------------------------------------
module gmh_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic [7:0] repeat_count,
  input logic       end_of_line,
  input logic       last
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("Block not empty after reset.");

  a_eol_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && end_of_line |-> last)
    else $error("Line end on an item that is not the last of its input.");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    !empty && repeat_count == 8'd0 |-> end_of_line && out_byte == 8'h00)
    else $error("Zero repeat count on an item that is not a bare line marker.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(repeat_count)
      && $stable(end_of_line) && $stable(last))
    else $error("Waiting result item changed while stalled.");

endmodule

bind guide_markup_to_html_stream gmh_checker u_gmh_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .out_byte     (out_byte),
  .repeat_count (repeat_count),
  .end_of_line  (end_of_line),
  .last         (last)
);
